// ===== src/psd_pkg.sv =====
// Package for the pairwise squared distance block: field widths, register
// indexes, opcodes and parameter defaults. No dependencies.
package psd_pkg;

  localparam int DEF_MAX_POINTS  = 64;
  localparam int DEF_MAX_DIMS    = 16;
  localparam int DEF_COORD_WIDTH = 16;

  localparam int DIST_W     = 36;
  localparam int PIDX_W     = 6;
  localparam int NP_CFG_W   = 7;
  localparam int ND_CFG_W   = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_POINTS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_DIMS   = 1'b1;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

endpackage

// ===== src/psd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module psd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/psd_cell.sv =====
// One accumulator cell of the rotating ring; takes its neighbour's value on
// every shift. Depends on psd_pkg.
module psd_cell #(
  parameter int WIDTH = psd_pkg::DIST_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             shift_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);
  import psd_pkg::*;

  logic [WIDTH-1:0] acc_q;
  logic [WIDTH-1:0] acc_d;

  assign acc_d = shift_i ? d_i : acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign q_o = acc_q;

endmodule

// ===== src/pairwise_squared_distance.sv =====
// A load word is written into the store when accepted. For a query word the accumulator
// ring makes one full turn through the single read / subtract-square / saturating-add
// head, one cell per cycle unless the output stalls; no word is taken in the turn.
// On a query point's last coordinate one result per point leaves during that turn.
// Reset: positions, config (1, 1), accumulators and handshake state cleared;
// the reference store is not cleared and holds nothing until loaded.
module pairwise_squared_distance #(
  parameter int MAX_POINTS  = psd_pkg::DEF_MAX_POINTS,
  parameter int MAX_DIMS    = psd_pkg::DEF_MAX_DIMS,
  parameter int COORD_WIDTH = psd_pkg::DEF_COORD_WIDTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             opcode_i,
  input  logic signed [COORD_WIDTH-1:0]    coordinate_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [psd_pkg::DIST_W-1:0]       distance_o,
  output logic [psd_pkg::PIDX_W-1:0]       point_index_o,
  output logic                             last_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [psd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [psd_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import psd_pkg::*;

  localparam int DEPTH    = MAX_POINTS * MAX_DIMS;
  localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int DIMS_CAP = (MAX_DIMS < 31) ? MAX_DIMS : 31;
  localparam int QP_W     = (DIMS_CAP > 1) ? $clog2(DIMS_CAP) : 1;
  localparam int QC_W     = ND_CFG_W + 1;
  localparam int MAG_W    = COORD_WIDTH + 1;
  localparam int SQ_W     = 2 * MAG_W;
  localparam int SUM_W    = ((SQ_W > DIST_W) ? SQ_W : DIST_W) + 1;
  localparam int TOT_W    = NP_CFG_W + ND_CFG_W;
  localparam int LPC_W    = ((TOT_W > AW) ? TOT_W : AW) + 1;
  localparam logic [SUM_W-1:0] DIST_MAX = {{(SUM_W-DIST_W){1'b0}}, {DIST_W{1'b1}}};

  // configuration
  logic [NP_CFG_W-1:0] num_points_q;
  logic [ND_CFG_W-1:0] num_dims_q;
  logic [NP_CFG_W-1:0] eff_np;
  logic [ND_CFG_W-1:0] eff_nd;
  logic [TOT_W-1:0]    total;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_points_q <= NP_CFG_W'(1);
      num_dims_q   <= ND_CFG_W'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_NUM_POINTS: num_points_q <= cfg_data_i[NP_CFG_W-1:0];
        REG_NUM_DIMS:   num_dims_q   <= cfg_data_i[ND_CFG_W-1:0];
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (num_points_q == '0) begin
      eff_np = NP_CFG_W'(1);
    end else if (32'(num_points_q) > MAX_POINTS) begin
      eff_np = NP_CFG_W'(MAX_POINTS);
    end else begin
      eff_np = num_points_q;
    end
    if (num_dims_q == '0) begin
      eff_nd = ND_CFG_W'(1);
    end else if (32'(num_dims_q) > MAX_DIMS) begin
      eff_nd = ND_CFG_W'(MAX_DIMS);
    end else begin
      eff_nd = num_dims_q;
    end
  end

  assign total = TOT_W'(eff_np) * TOT_W'(eff_nd);

  // handshake
  logic a_active_q, b_valid_q, c_valid_q;
  logic busy, load_accept, query_accept;

  assign busy         = a_active_q | b_valid_q | c_valid_q;
  assign in_ready_o   = ~busy;
  assign load_accept  = in_valid_i & in_ready_o & (opcode_i == OP_LOAD);
  assign query_accept = in_valid_i & in_ready_o & (opcode_i == OP_QUERY);

  // load position
  logic [AW-1:0]    lp_q;
  logic [LPC_W-1:0] lp_ext, tot_ext, lp_eff, lp_inc, lp_next;

  assign lp_ext  = LPC_W'(lp_q);
  assign tot_ext = LPC_W'(total);
  assign lp_eff  = (lp_ext >= tot_ext) ? '0 : lp_ext;
  assign lp_inc  = lp_eff + LPC_W'(1);
  assign lp_next = (lp_inc >= tot_ext) ? '0 : lp_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lp_q <= '0;
    end else if (load_accept) begin
      lp_q <= lp_next[AW-1:0];
    end
  end

  // query position
  logic [QP_W-1:0] qp_q, qp_eff;
  logic [QC_W-1:0] nd_ext, qp_inc;
  logic            qp_final;

  assign nd_ext   = QC_W'(eff_nd);
  assign qp_eff   = (QC_W'(qp_q) >= nd_ext) ? '0 : qp_q;
  assign qp_inc   = QC_W'(qp_eff) + QC_W'(1);
  assign qp_final = qp_inc >= nd_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qp_q <= '0;
    end else if (query_accept) begin
      qp_q <= qp_final ? '0 : qp_inc[QP_W-1:0];
    end
  end

  // word held for the whole turn
  logic signed [COORD_WIDTH-1:0] coord_q;
  logic                          clear_q, emit_q;

  always_ff @(posedge clk_i) begin
    if (query_accept) begin
      coord_q <= coordinate_i;
      clear_q <= (qp_eff == '0);
      emit_q  <= qp_final;
    end
  end

  // pipeline control
  logic             en, stall;
  logic [CNT_W-1:0] a_idx_q, b_idx_q, c_idx_q;
  logic [AW-1:0]    a_addr_q;
  logic [AW:0]      a_addr_inc;
  logic             c_in_use, c_emit, c_last;

  assign c_in_use = NP_CFG_W'(c_idx_q) < eff_np;
  assign c_emit   = emit_q & c_in_use;
  assign c_last   = NP_CFG_W'(c_idx_q) == (eff_np - NP_CFG_W'(1));
  assign stall    = c_valid_q & c_emit & out_valid_o & ~out_ready_i;
  assign en       = ~stall;

  assign a_addr_inc = (AW+1)'(a_addr_q) + (AW+1)'(eff_nd);

  // stage A: store read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_active_q <= 1'b0;
      a_idx_q    <= '0;
    end else if (query_accept) begin
      a_active_q <= 1'b1;
      a_idx_q    <= '0;
    end else if (en && a_active_q) begin
      a_idx_q <= a_idx_q + CNT_W'(1);
      if (a_idx_q == CNT_W'(MAX_POINTS - 1)) begin
        a_active_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (query_accept) begin
      a_addr_q <= AW'(qp_eff);
    end else if (en && a_active_q) begin
      a_addr_q <= a_addr_inc[AW-1:0];
    end
  end

  logic [COORD_WIDTH-1:0] rdata;

  psd_ram #(
    .WIDTH (COORD_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (load_accept),
    .waddr_i (lp_eff[AW-1:0]),
    .wdata_i (coordinate_i),
    .re_i    (en & a_active_q),
    .raddr_i (a_addr_q),
    .rdata_o (rdata)
  );

  // stage B: difference and square
  logic signed [MAG_W-1:0] diff;
  logic [MAG_W-1:0]        mag;
  logic [SQ_W-1:0]         sq, sq_q;

  assign diff = $signed({coord_q[COORD_WIDTH-1], coord_q})
              - $signed({rdata[COORD_WIDTH-1], rdata});
  assign mag  = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
  assign sq   = mag * mag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else if (en) begin
      b_valid_q <= a_active_q;
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_idx_q <= a_idx_q;
      c_idx_q <= b_idx_q;
      sq_q    <= sq;
    end
  end

  // stage C: saturating add at the ring head
  logic [DIST_W-1:0] ring [MAX_POINTS];
  logic [DIST_W-1:0] base, sat, head;
  logic [SUM_W-1:0]  sum;
  logic              ring_shift;

  assign base       = clear_q ? '0 : ring[0];
  assign sum        = SUM_W'(base) + SUM_W'(sq_q);
  assign sat        = (sum > DIST_MAX) ? DIST_MAX[DIST_W-1:0] : sum[DIST_W-1:0];
  assign head       = c_in_use ? sat : base;
  assign ring_shift = en & c_valid_q;

  for (genvar p = 0; p < MAX_POINTS; p++) begin : g_ring
    if (p == MAX_POINTS - 1) begin : g_tail
      psd_cell #(.WIDTH(DIST_W)) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (ring_shift),
        .d_i     (head),
        .q_o     (ring[p])
      );
    end else begin : g_mid
      psd_cell #(.WIDTH(DIST_W)) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (ring_shift),
        .d_i     (ring[p+1]),
        .q_o     (ring[p])
      );
    end
  end

  // output register
  logic              out_valid_q;
  logic [DIST_W-1:0] dist_q;
  logic [PIDX_W-1:0] pidx_q;
  logic              last_q;
  logic              out_load;

  assign out_load = en & c_valid_q & c_emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      dist_q <= head;
      pidx_q <= PIDX_W'(c_idx_q);
      last_q <= c_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign distance_o    = dist_q;
  assign point_index_o = pidx_q;
  assign last_o        = last_q;

  // checks
  a_turn_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (c_valid_q && c_idx_q == CNT_W'(MAX_POINTS - 1)) |-> (!a_active_q && !b_valid_q))
    else $error("read stages still busy at end of turn");

  a_idx_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_valid_q && c_valid_q) |->
      ((CNT_W+1)'(c_idx_q) + (CNT_W+1)'(1) == (CNT_W+1)'(b_idx_q)))
    else $error("point indices out of order between stages");

  a_turn_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(a_active_q) |-> $past(in_valid_i && in_ready_o && opcode_i == OP_QUERY))
    else $error("turn started without a query word");

endmodule

// ===== verif/psd_checker.sv =====
// Checker for pairwise_squared_distance: follows register, load and query words,
// predicts every distance word and compares the results in arrival order.
// Depends on psd_pkg only.
module psd_checker
  import psd_pkg::*;
#(
  parameter int MAX_POINTS  = DEF_MAX_POINTS,
  parameter int MAX_DIMS    = DEF_MAX_DIMS,
  parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic                          opcode_i,
  input  logic signed [COORD_WIDTH-1:0] coordinate_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [DIST_W-1:0]             distance_i,
  input  logic [PIDX_W-1:0]             point_index_i,
  input  logic                          last_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i,
  output int                            fail_count_o,
  output int                            pending_o
);

  localparam longint unsigned DIST_TOP = (64'd1 << DIST_W) - 64'd1;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [PIDX_W-1:0] point_index;
    logic              last_flag;
  } distance_word_t;

  distance_word_t                awaited_q[$];
  logic signed [COORD_WIDTH-1:0] ref_coords [MAX_POINTS*MAX_DIMS];
  longint unsigned               sums [MAX_POINTS];
  int unsigned                   load_pos;
  int unsigned                   query_pos;
  logic [NP_CFG_W-1:0]           points_reg;
  logic [ND_CFG_W-1:0]           dims_reg;

  function automatic int unsigned active_points();
    if (points_reg == 0) return 1;
    if (points_reg > MAX_POINTS) return MAX_POINTS;
    return 32'(points_reg);
  endfunction

  function automatic int unsigned active_dims();
    if (dims_reg == 0) return 1;
    if (dims_reg > MAX_DIMS) return MAX_DIMS;
    return 32'(dims_reg);
  endfunction

  task automatic report(input string field, input longint unsigned want,
                        input longint unsigned got);
    fail_count_o++;
    $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
  endtask

  task automatic absorb_word(input logic op, input logic signed [COORD_WIDTH-1:0] c);
    int unsigned     np;
    int unsigned     nd;
    int unsigned     total;
    int unsigned     p;
    int unsigned     addr;
    longint          diff;
    longint unsigned sq;
    distance_word_t  w;
    np = active_points();
    nd = active_dims();
    if (op == OP_LOAD) begin
      total = np * nd;
      if (load_pos >= total) load_pos = 0;
      ref_coords[load_pos] = c;
      load_pos = (load_pos + 1 >= total) ? 0 : load_pos + 1;
    end else begin
      if (query_pos >= nd) query_pos = 0;
      if (query_pos == 0) begin
        foreach (sums[i]) sums[i] = 0;
      end
      for (p = 0; p < np; p++) begin
        addr = p * nd + query_pos;
        diff = longint'(c) - longint'(ref_coords[addr]);
        sq   = longint'(diff * diff);
        if (sums[p] > DIST_TOP || sq > DIST_TOP - sums[p]) sums[p] = DIST_TOP;
        else sums[p] += sq;
      end
      if (query_pos + 1 < nd) begin
        query_pos++;
      end else begin
        query_pos = 0;
        for (p = 0; p < np; p++) begin
          w.distance    = DIST_W'(sums[p]);
          w.point_index = PIDX_W'(p);
          w.last_flag   = (p + 1 == np);
          awaited_q.push_back(w);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    distance_word_t want;
    if (!rst_ni) begin
      awaited_q.delete();
      foreach (ref_coords[a]) ref_coords[a] = '0;
      foreach (sums[a]) sums[a] = 0;
      load_pos     = 0;
      query_pos    = 0;
      points_reg   = 1;
      dims_reg     = 1;
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_NUM_POINTS) points_reg = cfg_data_i[NP_CFG_W-1:0];
        else if (cfg_index_i == REG_NUM_DIMS) dims_reg = cfg_data_i[ND_CFG_W-1:0];
      end
      if (in_valid_i && in_ready_i) absorb_word(opcode_i, coordinate_i);
      if (out_valid_i && out_ready_i) begin
        if (awaited_q.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected distance word: expected none, actual %0d/%0d/%0b",
                   $time, distance_i, point_index_i, last_i);
        end else begin
          want = awaited_q.pop_front();
          if (distance_i !== want.distance) report("distance", want.distance, distance_i);
          if (point_index_i !== want.point_index)
            report("point_index", want.point_index, point_index_i);
          if (last_i !== want.last_flag) report("last", want.last_flag, last_i);
        end
      end
      pending_o = awaited_q.size();
    end
  end

endmodule

// ===== verif/pairwise_squared_distance_tb.sv =====
// Testbench top for pairwise_squared_distance: drives register, load and query
// words with random back-pressure and gives the verdict.
// Depends on psd_pkg, pairwise_squared_distance and psd_checker.
module pairwise_squared_distance_tb;
  import psd_pkg::*;

  localparam int NPTS           = DEF_MAX_POINTS;
  localparam int NDIMS          = DEF_MAX_DIMS;
  localparam int CW             = DEF_COORD_WIDTH;
  localparam int SETTLE_CYCLES  = NPTS + 8;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int TOTAL_WORDS    = 330;
  localparam int CALM_WORDS     = 60;
  localparam int FILL_CAP       = 128;

  localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  opcode;
  logic signed [CW-1:0]  coordinate;
  logic                  out_valid;
  logic                  out_ready;
  logic [DIST_W-1:0]     distance;
  logic [PIDX_W-1:0]     point_index;
  logic                  last_flag;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int          fail_count;
  int          pending;
  bit          calm;
  int unsigned points_raw;
  int unsigned dims_raw;
  int unsigned load_at;
  int unsigned idle_cycles;
  int unsigned sent;
  bit          loaded [NPTS*NDIMS];

  pairwise_squared_distance #(
    .MAX_POINTS (NPTS),
    .MAX_DIMS   (NDIMS),
    .COORD_WIDTH(CW)
  ) DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .opcode_i     (opcode),
    .coordinate_i (coordinate),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .distance_o   (distance),
    .point_index_o(point_index),
    .last_o       (last_flag),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  psd_checker #(
    .MAX_POINTS (NPTS),
    .MAX_DIMS   (NDIMS),
    .COORD_WIDTH(CW)
  ) distance_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .opcode_i     (opcode),
    .coordinate_i (coordinate),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .distance_i   (distance),
    .point_index_i(point_index),
    .last_i       (last_flag),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic int unsigned clip(input int unsigned raw, input int unsigned ceiling);
    return (raw == 0) ? 1 : (raw > ceiling) ? ceiling : raw;
  endfunction

  function automatic logic signed [CW-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return COORD_MIN;
      1:       return COORD_MAX;
      2:       return '0;
      3:       return '1;
      default: return CW'($urandom);
    endcase
  endfunction

  // valid is left high after acceptance; the next word or settle() decides
  task automatic send_word(input logic op, input logic signed [CW-1:0] c);
    int unsigned total;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    coordinate <= c;
    do @(posedge clk); while (!in_ready);
    sent++;
    if (op == OP_LOAD) begin
      total = clip(points_raw, NPTS) * clip(dims_raw, NDIMS);
      if (load_at >= total) load_at = 0;
      loaded[load_at] = 1'b1;
      load_at = (load_at + 1 >= total) ? 0 : load_at + 1;
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // every store entry a query can reach must hold a loaded coordinate
  task automatic fill_store();
    int unsigned total;
    int unsigned a;
    bit          hole;
    total = clip(points_raw, NPTS) * clip(dims_raw, NDIMS);
    do begin
      hole = 1'b0;
      for (a = 0; a < total; a++) if (!loaded[a]) hole = 1'b1;
      if (hole) send_word(OP_LOAD, rand_coord());
    end while (hole);
  endtask

  task automatic write_config(input int unsigned np_raw, input int unsigned nd_raw);
    cfg_valid <= 1'b1;
    cfg_index <= REG_NUM_POINTS;
    cfg_data  <= CFG_DATA_W'(np_raw);
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_NUM_DIMS;
    cfg_data  <= CFG_DATA_W'(nd_raw);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    points_raw  = np_raw;
    dims_raw    = nd_raw;
    fill_store();
  endtask

  initial begin
    int unsigned run_len;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 2) != 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      out_ready <= 1'b1;
      run_len = $urandom_range(1, 40);
      repeat (run_len) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("pairwise_squared_distance_tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    int unsigned np_pick;
    int unsigned nd_pick;
    int unsigned nd_eff;
    int unsigned k;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    opcode      = OP_LOAD;
    coordinate  = '0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_NUM_POINTS;
    cfg_data    = '0;
    calm        = 1'b0;
    points_raw  = 1;
    dims_raw    = 1;
    load_at     = 0;
    sent        = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // coordinate extremes, then a load past the end wraps to point 0
    write_config(3, 2);
    send_word(OP_LOAD, COORD_MIN);
    send_word(OP_LOAD, COORD_MAX);
    send_word(OP_LOAD, 0);
    send_word(OP_LOAD, -1);
    send_word(OP_LOAD, 1);
    send_word(OP_LOAD, COORD_MAX);
    send_word(OP_QUERY, COORD_MAX);
    send_word(OP_QUERY, COORD_MIN);
    send_word(OP_QUERY, COORD_MIN);
    send_word(OP_QUERY, COORD_MAX);
    send_word(OP_LOAD, 5);
    send_word(OP_QUERY, 0);
    send_word(OP_QUERY, 0);
    settle();

    // zero registers act as one; load position beyond the new size restarts
    write_config(0, 0);
    send_word(OP_LOAD, -1);
    send_word(OP_QUERY, COORD_MAX);
    settle();

    // query position beyond a shrunk dimension count restarts the point
    write_config(2, 4);
    send_word(OP_QUERY, rand_coord());
    send_word(OP_QUERY, rand_coord());
    send_word(OP_QUERY, rand_coord());
    settle();
    write_config(2, 2);
    send_word(OP_QUERY, rand_coord());
    send_word(OP_QUERY, rand_coord());
    settle();

    // largest possible distance, dimension count above its maximum
    write_config(1, 31);
    repeat (NDIMS) send_word(OP_LOAD, COORD_MIN);
    repeat (NDIMS) send_word(OP_QUERY, COORD_MAX);
    settle();

    // random phases, the first with the point count above its maximum
    np_pick = 127;
    nd_pick = 2;
    while (sent < TOTAL_WORDS) begin
      write_config(np_pick, nd_pick);
      nd_eff = clip(nd_pick, NDIMS);
      repeat ($urandom_range(1, 4)) begin
        for (k = 0; k < nd_eff; k++) begin
          if ($urandom_range(0, 7) == 0) begin
            send_word(OP_LOAD, rand_coord());
          end
          if (k > 0 && $urandom_range(0, 19) == 0) break;
          send_word(OP_QUERY, rand_coord());
        end
      end
      calm = (sent + CALM_WORDS >= TOTAL_WORDS);
      settle();
      case ($urandom_range(0, 9))
        0:       np_pick = 0;
        1:       np_pick = $urandom_range(NPTS + 1, 127);
        2:       np_pick = NPTS;
        default: np_pick = $urandom_range(1, 8);
      endcase
      case ($urandom_range(0, 9))
        0:       nd_pick = 0;
        1:       nd_pick = $urandom_range(NDIMS + 1, 31);
        2:       nd_pick = NDIMS;
        default: nd_pick = $urandom_range(1, 4);
      endcase
      // keep the part of the store in use small enough to fill quickly
      if (clip(np_pick, NPTS) * clip(nd_pick, NDIMS) > FILL_CAP)
        nd_pick = $urandom_range(1, 2);
    end

    if (fail_count == 0)
      $display("pairwise_squared_distance_tb OK");
    else
      $display("pairwise_squared_distance_tb NOT OK");
    $finish;
  end

endmodule

// ===== pairwise_squared_distance.f =====
src/psd_pkg.sv
src/psd_ram.sv
src/psd_cell.sv
src/pairwise_squared_distance.sv
verif/psd_checker.sv
verif/pairwise_squared_distance_tb.sv
